/* rtl/fmms_pkg.sv */
`default_nettype none
package fmms_pkg;

  localparam int unsigned WordBytes = 10;

  typedef enum logic [1:0] {
    ST_TOKEN   = 2'd0,
    ST_STORED  = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_NEXT_LEN,
    S_EMIT,
    S_OUT
  } fsm_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic take_item;
    logic do_load;
    logic scan_start;
    logic scan_step;
    logic len_dec;
    logic emit;
    logic ack;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_load;
    logic need_emit;
    logic scan_done;
    logic hit;
    logic len_one;
  } dp_sts_t;

endpackage
`default_nettype wire

/* rtl/fmms_datapath.sv */
`default_nettype none
module fmms_datapath
  import fmms_pkg::*;
#(
  parameter int unsigned MAX_WORD     = 10,
  parameter int unsigned DICT_ENTRIES = 256,
  parameter int unsigned AW           = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire dp_cmd_t      cmd,
  output dp_sts_t           sts,
  input  wire logic         in_req_type,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_last,
  input  wire logic [63:0]  in_word_low,
  input  wire logic [15:0]  in_word_high,
  input  wire logic [3:0]   in_word_length,
  input  wire logic [3:0]   max_len,
  output logic [1:0]        res_status,
  output logic [3:0]        res_len,
  output logic              res_hit,
  output logic              res_last
);

  localparam int unsigned CW = $clog2(DICT_ENTRIES + 1);
  localparam int unsigned WB = WordBytes;

  logic [8*WB-1:0] dict_mem [DICT_ENTRIES];
  logic [3:0]      dlen_mem [DICT_ENTRIES];
  logic [8*WB-1:0] rd_word_r;
  logic [3:0]      rd_len_r;
  logic            rd_vld_r;

  logic [7:0]    win_r [MAX_WORD];
  logic [3:0]    cnt_r;
  logic [CW-1:0] dcnt_r;
  logic [CW-1:0] ptr_r;
  logic [3:0]    len_r;
  logic          hit_r;
  logic          flush_r;
  logic          load_r;
  logic [8*WB-1:0] word_r;
  logic [3:0]    wlen_r;

  logic [3:0] eff_max;
  logic [3:0] limit;
  logic       cmp_eq;
  logic [3:0] take;
  logic [3:0] sat_len;
  logic [8*WB-1:0] word_in;
  logic [8*WB-1:0] masked;
  logic [7:0]    win_shift [MAX_WORD];
  logic [AW-1:0] rd_addr;

  always_comb begin
    eff_max = max_len;
    if (max_len == 4'd0) eff_max = 4'd1;
    if (max_len > 4'(MAX_WORD)) eff_max = 4'(MAX_WORD);
    limit = flush_r ? ((eff_max < cnt_r) ? eff_max : cnt_r) : eff_max;
    sat_len = (in_word_length > 4'(MAX_WORD)) ? 4'(MAX_WORD) : in_word_length;
    word_in = {in_word_high, in_word_low};
    for (int i = 0; i < WB; i++) begin
      masked[8*i +: 8] = (i < int'(sat_len)) ? word_in[8*i +: 8] : 8'd0;
    end
    cmp_eq = rd_vld_r && (rd_len_r == len_r);
    for (int i = 0; i < MAX_WORD; i++) begin
      if (i < int'(len_r) && rd_word_r[8*i +: 8] != win_r[i]) cmp_eq = 1'b0;
    end
    take = hit_r ? len_r : 4'd1;
    // window after dropping the token at its head
    for (int i = 0; i < MAX_WORD; i++) begin
      win_shift[i] = 8'd0;
      for (int j = 0; j < MAX_WORD; j++) begin
        if (j == i + int'(take) && j < int'(cnt_r)) win_shift[i] = win_r[j];
      end
    end
    // address of the entry that rd_word_r holds in the next cycle
    if (cmd.scan_start || cmd.len_dec) rd_addr = '0;
    else if (cmd.scan_step) rd_addr = ptr_r[AW-1:0] + AW'(1);
    else rd_addr = ptr_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    rd_word_r <= dict_mem[rd_addr];
    rd_len_r  <= dlen_mem[rd_addr];
    if (cmd.do_load && dcnt_r < CW'(DICT_ENTRIES)) begin
      dict_mem[dcnt_r[AW-1:0]] <= word_r;
      dlen_mem[dcnt_r[AW-1:0]] <= wlen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; dcnt_r <= '0; ptr_r <= '0; rd_vld_r <= 1'b0;
      len_r <= '0; hit_r <= 1'b0; flush_r <= 1'b0; load_r <= 1'b0;
      for (int i = 0; i < MAX_WORD; i++) win_r[i] <= 8'd0;
      res_status <= '0; res_len <= '0; res_hit <= 1'b0; res_last <= 1'b0;
    end else begin
      rd_vld_r <= 1'b0;
      if (cmd.take_item) begin
        load_r <= !in_req_type;
        word_r <= masked;
        wlen_r <= sat_len;
        if (in_req_type) begin
          flush_r <= in_last;
          if (cnt_r < 4'(MAX_WORD)) begin
            win_r[cnt_r[$clog2(MAX_WORD+1)-1:0]] <= in_byte;
            cnt_r <= cnt_r + 4'd1;
          end
        end
      end
      if (cmd.do_load && dcnt_r < CW'(DICT_ENTRIES)) begin
        dcnt_r <= dcnt_r + CW'(1);
      end
      if (cmd.ack) begin
        res_status <= (dcnt_r < CW'(DICT_ENTRIES)) ? ST_STORED : ST_DROPPED;
        res_len <= '0; res_hit <= 1'b0; res_last <= 1'b1;
      end
      if (cmd.scan_start) begin
        len_r <= limit; hit_r <= 1'b0; ptr_r <= '0;
        rd_vld_r <= (dcnt_r != '0);
      end
      if (cmd.scan_step) begin
        if (cmp_eq) hit_r <= 1'b1;
        ptr_r <= ptr_r + CW'(1);
        rd_vld_r <= (ptr_r + CW'(1)) < dcnt_r && !cmp_eq;
      end
      if (cmd.len_dec) begin
        len_r <= len_r - 4'd1; ptr_r <= '0; rd_vld_r <= (dcnt_r != '0);
      end
      if (cmd.emit) begin
        for (int i = 0; i < MAX_WORD; i++) begin
          win_r[i] <= win_shift[i];
        end
        cnt_r <= cnt_r - take;
        res_status <= ST_TOKEN;
        res_len <= take;
        res_hit <= hit_r;
        res_last <= flush_r && (cnt_r == take);
      end
    end
  end

  always_comb begin
    sts.is_load   = load_r;
    sts.need_emit = flush_r ? (cnt_r != 4'd0) : (cnt_r >= eff_max);
    sts.scan_done = !rd_vld_r || cmp_eq;
    sts.hit       = cmp_eq || hit_r;
    sts.len_one   = (len_r <= 4'd1);
  end

endmodule
`default_nettype wire

/* rtl/fmms_ctrl.sv */
`default_nettype none
module fmms_ctrl
  import fmms_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_fire,
  input  wire logic    out_taken,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd,
  output logic         in_rdy,
  output logic         out_vld
);

  fsm_state_t state_r, state_nxt;
  logic ack_r, ack_nxt;

  always_comb begin
    state_nxt = state_r;
    ack_nxt = ack_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_LOAD;
      S_LOAD: begin
        if (sts.is_load) begin
          state_nxt = S_OUT; ack_nxt = 1'b1;
        end else if (sts.need_emit) state_nxt = S_SCAN;
        else state_nxt = S_IDLE;
      end
      S_SCAN: if (sts.scan_done) state_nxt = S_NEXT_LEN;
      S_NEXT_LEN: begin
        if (sts.hit || sts.len_one) state_nxt = S_EMIT;
        else state_nxt = S_SCAN;
      end
      S_EMIT: begin
        state_nxt = S_OUT; ack_nxt = 1'b0;
      end
      S_OUT: begin
        if (out_taken) begin
          if (ack_r) state_nxt = S_IDLE;
          else if (sts.need_emit) state_nxt = S_SCAN;
          else state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_rdy = 1'b0;
    out_vld = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_rdy = 1'b1; cmd.take_item = in_fire;
      end
      S_LOAD: begin
        cmd.do_load = sts.is_load;
        cmd.scan_start = !sts.is_load && sts.need_emit;
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_NEXT_LEN: cmd.len_dec = !(sts.hit || sts.len_one);
      S_EMIT: cmd.emit = 1'b1;
      S_OUT: begin
        out_vld = 1'b1;
        cmd.ack = 1'b0;
        cmd.scan_start = out_taken && !ack_r && sts.need_emit;
      end
      default: ;
    endcase
    if (state_r == S_LOAD && sts.is_load) cmd.ack = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ack_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ack_r <= ack_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/forward_maximum_match_segmenter_unit.sv */
`default_nettype none
// Greedy longest-match byte segmenter. Load items (tuser=0) append a word to
// the dictionary table and return one ack (status 1 stored, 2 dropped when
// full). Text bytes (tuser=1) fill a window; once it holds max_len bytes, or
// on a byte with tlast, tokens are produced longest-match-first. A load is
// written to the table and acknowledged, then waits for the output handshake.
// Each token scans the stored words through one memory read port, one entry
// per cycle, for each candidate length. Results wait in an output register; a
// new item is taken once all results of the last one left.
module forward_maximum_match_segmenter_unit
  import fmms_pkg::*;
#(
  parameter int unsigned MAX_WORD     = 10,
  parameter int unsigned DICT_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: text_byte[7:0], word_low[71:8], word_high[87:72], word_length[91:88]
  input  wire logic [95:0] in_tdata,
  input  wire logic        in_tlast,   // text_last
  input  wire logic        in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: status[1:0], token_length[5:2], in_dictionary[6]
  output logic [7:0]       out_tdata,
  output logic             out_tlast,  // last_of_run
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);

  localparam int unsigned AW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [3:0] max_len_r;
  logic [1:0] st;
  logic [3:0] tl;
  logic hit;

  assign cfg_ready = 1'b1;
  // hold max_len; the user must ensure writes only arrive while idle (unenforced)
  always_ff @(posedge clk) begin
    if (!rst_n) max_len_r <= 4'd10;
    else if (cfg_valid) max_len_r <= cfg_data;
  end

  fmms_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire(in_tvalid && in_tready),
    .out_taken(out_tvalid && out_tready),
    .sts, .cmd,
    .in_rdy(in_tready),
    .out_vld(out_tvalid)
  );

  fmms_datapath #(.MAX_WORD(MAX_WORD), .DICT_ENTRIES(DICT_ENTRIES), .AW(AW)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_req_type(in_tuser),
    .in_byte(in_tdata[7:0]),
    .in_last(in_tlast),
    .in_word_low(in_tdata[71:8]),
    .in_word_high(in_tdata[87:72]),
    .in_word_length(in_tdata[91:88]),
    .max_len(max_len_r),
    .res_status(st), .res_len(tl), .res_hit(hit), .res_last(out_tlast)
  );

  assign out_tdata = {1'b0, hit, tl, st};

endmodule
`default_nettype wire

/* rtl/fmms_checker.sv */
`default_nettype none
module fmms_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tlast)
    else $error("load ack without last");
  a_tok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == 2'd0 |-> out_tdata[5:2] != 4'd0)
    else $error("empty token");
endmodule

bind forward_maximum_match_segmenter_unit fmms_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);
`default_nettype wire
